// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the window writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define LWF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked outside reset.
`define LWF_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define LWF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/lwf_pkg.sv -----
// Types, constants and helper functions of the LCD window fill writer.
package lwf_pkg;

    typedef enum logic [1:0] {
        KIND_ROTATE = 2'd0,
        KIND_WINDOW = 2'd1,
        KIND_PIXELS = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CHECK = 2'd1,
        ST_AREA  = 2'd2,
        ST_EMIT  = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic check;
        logic area;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_ok;
        logic burst_zero;
        logic emit_last;
        logic out_ok;
    } t_dp_sts;

    localparam logic [7:0] OP_COLSET = 8'h2A;
    localparam logic [7:0] OP_ROWSET = 8'h2B;
    localparam logic [7:0] OP_MEMWR  = 8'h2C;
    localparam logic [7:0] OP_ACCESS = 8'h36;
    localparam logic [7:0] ACC_MY    = 8'h80;
    localparam logic [7:0] ACC_MX    = 8'h40;
    localparam logic [7:0] ACC_MV    = 8'h20;
    localparam logic [7:0] ACC_BGR   = 8'h08;

    localparam logic [16:0] LEFT_MAX = 17'h1FFFF;

    // Last byte index of the fixed-length sequences.
    localparam logic [5:0] ROT_LAST_IDX = 6'd1;
    localparam logic [5:0] WIN_LAST_IDX = 6'd10;

    // Memory access control byte for each orientation.
    function automatic logic [7:0] access_byte(input logic [1:0] rot);
        logic [7:0] b;
        case (rot)
            2'd0:    b = ACC_MX | ACC_BGR;
            2'd1:    b = ACC_MV | ACC_BGR;
            2'd2:    b = ACC_MY | ACC_BGR;
            default: b = ACC_MX | ACC_MY | ACC_MV | ACC_BGR;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/lwf_ctrl.sv -----
// Controller state machine of the LCD window fill writer.
module lwf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic [1:0]       i_kind,
    output logic             s_axis_tready,
    input  lwf_pkg::t_dp_sts i_sts,
    output lwf_pkg::t_dp_cmd o_cmd
);
    import lwf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   can_take;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new item may enter while the final byte of the previous one is stored.
    assign can_take = (r_state == ST_IDLE) ||
                      ((r_state == ST_EMIT) && i_sts.emit_last && i_sts.out_ok);
    assign take     = can_take && s_axis_tvalid;
    assign s_axis_tready = can_take;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.accept = take;
        case (r_state)
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.win_ok ? ST_AREA : ST_IDLE;
            end
            ST_AREA: begin
                o_cmd.area = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_ok;
                if (i_sts.out_ok && i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (take) begin
            case (t_kind'(i_kind))
                KIND_ROTATE: n_state = ST_EMIT;
                KIND_WINDOW: n_state = ST_CHECK;
                KIND_PIXELS: n_state = i_sts.burst_zero ? ST_IDLE : ST_EMIT;
                default:     n_state = ST_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"
    `LWF_ASSERT_IMP(a_ready_state, s_axis_tready,
        (r_state == ST_IDLE) || (r_state == ST_EMIT), "ready outside idle or emit")
    `LWF_ASSERT_IMP(a_emit_state, o_cmd.emit, r_state == ST_EMIT, "byte emitted outside emit")
    `LWF_ASSERT_NEXT(a_check_next, r_state == ST_CHECK,
        (r_state == ST_AREA) || (r_state == ST_IDLE), "bad state after window check")

endmodule

// ----- rtl/lwf_dp.sv -----
// Datapath of the LCD window fill writer: item store, screen state, clipping and byte output.
module lwf_dp #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320,
    parameter int MAX_BURST    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_kind,
    input  logic [63:0]      i_data,
    input  lwf_pkg::t_dp_cmd i_cmd,
    output lwf_pkg::t_dp_sts o_sts,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_is_data,
    output logic             o_last
);
    import lwf_pkg::*;

    localparam logic [8:0] PW        = 9'(PANEL_WIDTH);
    localparam logic [8:0] PH        = 9'(PANEL_HEIGHT);
    localparam logic [5:0] BURST_MAX = 6'(MAX_BURST);

    // Input fields.
    logic [1:0]  in_rot;
    logic [8:0]  in_x;
    logic [8:0]  in_y;
    logic [8:0]  in_w;
    logic [8:0]  in_h;
    logic [15:0] in_color;
    logic [5:0]  in_count;

    assign in_rot   = i_data[1:0];
    assign in_x     = i_data[10:2];
    assign in_y     = i_data[19:11];
    assign in_w     = i_data[28:20];
    assign in_h     = i_data[37:29];
    assign in_color = i_data[53:38];
    assign in_count = i_data[59:54];

    // Item and screen state.
    t_kind       r_kind;
    logic [8:0]  r_x;
    logic [8:0]  r_y;
    logic [8:0]  r_w;
    logic [8:0]  r_h;
    logic [8:0]  r_xe;
    logic [8:0]  r_ye;
    logic [15:0] r_color;
    logic [1:0]  r_orientation;
    logic [8:0]  r_scr_w;
    logic [8:0]  r_scr_h;
    logic [16:0] r_pixels_left;
    logic [5:0]  r_idx;
    logic [5:0]  r_last_idx;

    // Output register.
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_is_data;
    logic        r_last;

    // Burst length of a pixel item.
    logic [5:0]  cnt_lim;
    logic [5:0]  burst;
    always_comb begin
        cnt_lim = (in_count > BURST_MAX) ? BURST_MAX : in_count;
        burst   = ({11'd0, cnt_lim} > r_pixels_left) ? r_pixels_left[5:0] : cnt_lim;
    end

    // Window clipping against the current screen.
    logic [9:0]  x_sum;
    logic [9:0]  y_sum;
    logic [8:0]  clip_w;
    logic [8:0]  clip_h;
    logic        win_ok;
    always_comb begin
        x_sum  = {1'b0, r_x} + {1'b0, r_w};
        y_sum  = {1'b0, r_y} + {1'b0, r_h};
        clip_w = (x_sum > {1'b0, r_scr_w}) ? (r_scr_w - r_x) : r_w;
        clip_h = (y_sum > {1'b0, r_scr_h}) ? (r_scr_h - r_y) : r_h;
        win_ok = (r_w != 9'd0) && (r_h != 9'd0) && (r_x < r_scr_w) && (r_y < r_scr_h);
    end

    logic [17:0] area;
    assign area = r_w * r_h;

    logic        emit_last;
    assign emit_last = (r_idx == r_last_idx);

    // Byte selection for the current index.
    logic [7:0]  sel_byte;
    logic        sel_data;
    always_comb begin
        sel_byte = 8'd0;
        sel_data = 1'b1;
        case (r_kind)
            KIND_ROTATE: begin
                sel_data = r_idx[0];
                sel_byte = r_idx[0] ? access_byte(r_orientation) : OP_ACCESS;
            end
            KIND_WINDOW: begin
                case (r_idx)
                    6'd0: begin sel_byte = OP_COLSET; sel_data = 1'b0; end
                    6'd1:    sel_byte = {7'd0, r_x[8]};
                    6'd2:    sel_byte = r_x[7:0];
                    6'd3:    sel_byte = {7'd0, r_xe[8]};
                    6'd4:    sel_byte = r_xe[7:0];
                    6'd5: begin sel_byte = OP_ROWSET; sel_data = 1'b0; end
                    6'd6:    sel_byte = {7'd0, r_y[8]};
                    6'd7:    sel_byte = r_y[7:0];
                    6'd8:    sel_byte = {7'd0, r_ye[8]};
                    6'd9:    sel_byte = r_ye[7:0];
                    default: begin sel_byte = OP_MEMWR; sel_data = 1'b0; end
                endcase
            end
            default: begin
                sel_byte = r_idx[0] ? r_color[7:0] : r_color[15:8];
            end
        endcase
    end

    // Control and screen state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation <= 2'd0;
            r_scr_w       <= PW;
            r_scr_h       <= PH;
            r_pixels_left <= 17'd0;
            r_idx         <= 6'd0;
            r_last_idx    <= 6'd0;
            r_kind        <= KIND_NONE;
            r_valid       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_kind <= t_kind'(i_kind);
                r_idx  <= 6'd0;
                case (t_kind'(i_kind))
                    KIND_ROTATE: begin
                        r_orientation <= in_rot;
                        r_scr_w       <= in_rot[0] ? PH : PW;
                        r_scr_h       <= in_rot[0] ? PW : PH;
                        r_pixels_left <= 17'd0;
                        r_last_idx    <= ROT_LAST_IDX;
                    end
                    KIND_WINDOW: begin
                        r_last_idx <= WIN_LAST_IDX;
                    end
                    KIND_PIXELS: begin
                        r_pixels_left <= r_pixels_left - {11'd0, burst};
                        r_last_idx    <= 6'({burst, 1'b0} - 7'd1);
                    end
                    default: begin
                        r_last_idx <= 6'd0;
                    end
                endcase
            end else if (i_cmd.emit) begin
                r_idx <= r_idx + 6'd1;
            end
            if (i_cmd.area) begin
                r_pixels_left <= area[17] ? LEFT_MAX : area[16:0];
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x     <= in_x;
            r_y     <= in_y;
            r_w     <= in_w;
            r_h     <= in_h;
            r_color <= in_color;
        end
        if (i_cmd.check) begin
            r_w  <= clip_w;
            r_h  <= clip_h;
            r_xe <= 9'(r_x + clip_w - 9'd1);
            r_ye <= 9'(r_y + clip_h - 9'd1);
        end
        if (i_cmd.emit) begin
            r_byte    <= sel_byte;
            r_is_data <= sel_data;
            r_last    <= emit_last;
        end
    end

    assign o_sts.win_ok     = win_ok;
    assign o_sts.burst_zero = (burst == 6'd0);
    assign o_sts.emit_last  = emit_last;
    assign o_sts.out_ok     = !r_valid || i_ready;

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_is_data = r_is_data;
    assign o_last    = r_last;

`include "assert_macros.svh"
    `LWF_ASSERT_IMP(a_idx_range, i_cmd.emit, r_idx <= r_last_idx, "byte index past end")
    `LWF_ASSERT(a_screen_pair, ((r_scr_w == PW) && (r_scr_h == PH)) ||
        ((r_scr_w == PH) && (r_scr_h == PW)), "screen size not a panel orientation")

endmodule

// ----- rtl/lcd_window_fill_writer_top.sv -----
// Top level of the LCD window fill writer: panel byte stream with command/data flag.
//
//  Channel   Direction  tdata                                   tuser       tlast
//  s_axis    in         rotation,pos_x,pos_y,size_w,size_h,     cmd         -
//                       color,count
//  m_axis    out        link_byte                               is_data     last
//
// The output moves one link byte per cycle while m_axis accepts it. A rotate item
// sends 2 bytes, a pixel item 2 bytes per pixel sent, and a window item passes a check
// state, a state for the 9x9 area multiply, then 11 bytes. A rejected window passes
// the check state only; an empty pixel burst or an unused command sends no byte.
// The next item is accepted in the cycle the final byte of the current one enters
// the output register, so in that cycle s_axis_tready follows m_axis_tready.
// A stall on m_axis holds the output register and, through it, the byte sequencer.
// Reset is synchronous and active low; it restores orientation 0, the native
// panel size and an empty pixel budget.
module lcd_window_fill_writer_top #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320,
    parameter int MAX_BURST    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] rotation, [10:2] pos_x, [19:11] pos_y, [28:20] size_w, [37:29] size_h,
    // [53:38] color, [59:54] count, [63:60] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] link_byte
    output logic [7:0]  m_axis_tdata,
    // [0] is_data
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import lwf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller sequences check, area and byte emission for each item.
    lwf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .i_kind        (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    // The datapath holds the screen state and produces the bytes.
    lwf_dp #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .MAX_BURST    (MAX_BURST)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kind    (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_is_data (m_axis_tuser[0]),
        .o_last    (m_axis_tlast)
    );

endmodule

// ----- tb/tb_lcd_window_fill_writer_top.sv -----
// Self-checking testbench of the LCD window fill writer with a link byte predictor.
import lwf_pkg::*;

// One item on the input stream, every field present whatever the kind.
typedef struct packed {
    t_kind       kind;
    logic [1:0]  rotation;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [8:0]  size_w;
    logic [8:0]  size_h;
    logic [15:0] color;
    logic [5:0]  count;
} panel_item_t;

// One byte on the panel link with its D/C flag and end-of-item mark.
typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       last;
} link_byte_t;

// Tracks the panel state and holds the link bytes still owed by the block.
class link_byte_model;
    int          panel_w;
    int          panel_h;
    int          burst_max;
    logic [1:0]  orient;
    logic [8:0]  scr_w;
    logic [8:0]  scr_h;
    logic [16:0] budget;
    logic [7:0]  orient_code [4];
    link_byte_t  due_bytes [$];
    link_byte_t  fresh [$];
    int          failures;
    int          shown;

    function new(int w, int h, int b);
        panel_w   = w;
        panel_h   = h;
        burst_max = b;
        orient    = 2'd0;
        scr_w     = 9'(w);
        scr_h     = 9'(h);
        budget    = '0;
        failures  = 0;
        shown     = 0;
        orient_code[0] = ACC_MX | ACC_BGR;
        orient_code[1] = ACC_MV | ACC_BGR;
        orient_code[2] = ACC_MY | ACC_BGR;
        orient_code[3] = ACC_MX | ACC_MY | ACC_MV | ACC_BGR;
    endfunction

    function void put(logic [7:0] b, logic d);
        link_byte_t e;
        e.link_byte = b;
        e.is_data   = d;
        e.last      = 1'b0;
        fresh.push_back(e);
    endfunction

    // Address set command followed by big-endian start and end.
    function void put_span(logic [7:0] op, int a, int b);
        put(op, 1'b0);
        put(8'(a >> 8), 1'b1);
        put(8'(a), 1'b1);
        put(8'(b >> 8), 1'b1);
        put(8'(b), 1'b1);
    endfunction

    function void take_item(panel_item_t it);
        int x;
        int y;
        int w;
        int h;
        int k;
        int area;
        link_byte_t e;
        fresh.delete();
        case (it.kind)
            KIND_ROTATE: begin
                orient = it.rotation;
                // Odd orientations run the panel in landscape.
                scr_w  = it.rotation[0] ? 9'(panel_h) : 9'(panel_w);
                scr_h  = it.rotation[0] ? 9'(panel_w) : 9'(panel_h);
                budget = '0;
                put(OP_ACCESS, 1'b0);
                put(orient_code[it.rotation], 1'b1);
            end
            KIND_WINDOW: begin
                x = it.pos_x;
                y = it.pos_y;
                w = it.size_w;
                h = it.size_h;
                // Empty or off-screen rectangles send nothing and keep the budget.
                if (w != 0 && h != 0 && x < scr_w && y < scr_h) begin
                    if (x + w - 1 >= scr_w) w = scr_w - x;
                    if (y + h - 1 >= scr_h) h = scr_h - y;
                    put_span(OP_COLSET, x, x + w - 1);
                    put_span(OP_ROWSET, y, y + h - 1);
                    put(OP_MEMWR, 1'b0);
                    area   = w * h;
                    budget = (area > LEFT_MAX) ? LEFT_MAX : 17'(area);
                end
            end
            KIND_PIXELS: begin
                k = it.count;
                if (k > burst_max) k = burst_max;
                if (k > budget) k = budget;
                repeat (k) begin
                    put(it.color[15:8], 1'b1);
                    put(it.color[7:0], 1'b1);
                end
                budget = budget - 17'(k);
            end
            default: ;
        endcase
        foreach (fresh[i]) begin
            e      = fresh[i];
            e.last = (i == fresh.size() - 1);
            due_bytes.push_back(e);
        end
    endfunction

    function void match_byte(logic [7:0] b, logic d, logic l);
        link_byte_t want;
        if (due_bytes.size() == 0) begin
            failures++;
            if (shown < 10) begin
                shown++;
                $display("%0t: unexpected link byte %02h dc=%0b last=%0b", $time, b, d, l);
            end
            return;
        end
        want = due_bytes.pop_front();
        if (want.link_byte !== b || want.is_data !== d || want.last !== l) begin
            failures++;
            if (shown < 10) begin
                shown++;
                $display("%0t: link byte mismatch: expected %02h dc=%0b last=%0b, got %02h dc=%0b last=%0b",
                         $time, want.link_byte, want.is_data, want.last, b, d, l);
            end
        end
    endfunction
endclass

module tb_lcd_window_fill_writer_top;

    localparam int PANEL_W    = 240;
    localparam int PANEL_H    = 320;
    localparam int BURST_MAX  = 32;
    localparam int QUIET_MAX  = 4000;
    localparam int ITEM_GOAL  = 300;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] rotation, [10:2] pos_x, [19:11] pos_y, [28:20] size_w, [37:29] size_h,
    // [53:38] color, [59:54] count, [63:60] zero
    logic [63:0] s_axis_tdata  = '0;
    // [1:0] cmd
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] link_byte
    logic [7:0]  m_axis_tdata;
    // [0] is_data
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Set while both sides run without idling.
    bit             calm = 1'b0;
    int             quiet = 0;
    link_byte_model book;

    lcd_window_fill_writer_top #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H),
        .MAX_BURST   (BURST_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Link side: stall now and then, except during the calm stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            book.match_byte(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // All fields but the kind random; callers override the ones their kind uses.
    function automatic panel_item_t random_item();
        panel_item_t it;
        it.kind     = KIND_NONE;
        it.rotation = 2'($urandom);
        it.pos_x    = 9'($urandom);
        it.pos_y    = 9'($urandom);
        it.size_w   = 9'($urandom);
        it.size_h   = 9'($urandom);
        it.color    = 16'($urandom);
        it.count    = 6'($urandom);
        return it;
    endfunction

    // Called just after a falling edge; returns once the item has been accepted, just after a falling edge.
    task automatic push_item(input panel_item_t it);
        while (!calm && $urandom_range(0, 99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.count, it.color, it.size_h, it.size_w,
                          it.pos_y, it.pos_x, it.rotation};
        s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        book.take_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_rotate(input logic [1:0] r);
        panel_item_t it;
        it          = random_item();
        it.kind     = KIND_ROTATE;
        it.rotation = r;
        push_item(it);
    endtask

    task automatic send_window(input logic [8:0] x, input logic [8:0] y,
                               input logic [8:0] w, input logic [8:0] h);
        panel_item_t it;
        it        = random_item();
        it.kind   = KIND_WINDOW;
        it.pos_x  = x;
        it.pos_y  = y;
        it.size_w = w;
        it.size_h = h;
        push_item(it);
    endtask

    task automatic send_pixels(input logic [15:0] c, input logic [5:0] n);
        panel_item_t it;
        it       = random_item();
        it.kind  = KIND_PIXELS;
        it.color = c;
        it.count = n;
        push_item(it);
    endtask

    task automatic send_none();
        panel_item_t it;
        it      = random_item();
        it.kind = KIND_NONE;
        push_item(it);
    endtask

    // Holds the input off until the link has caught up with every item.
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (book.due_bytes.size() != 0);
    endtask

    initial begin : stimulus
        int         sent;
        int         next_pause;
        int         pick;
        int         n;
        logic [8:0] x;
        logic [8:0] y;
        logic [8:0] w;
        logic [8:0] h;

        book = new(PANEL_W, PANEL_H, BURST_MAX);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, starting from the portrait reset state.
        send_pixels(16'h1234, 6'd5);                 // no window open yet
        send_none();
        send_window(9'd0, 9'd0, 9'd240, 9'd320);     // whole screen
        send_pixels(16'hFFFF, 6'd0);                 // zero count
        send_pixels(16'hFFFF, 6'd63);                // capped at the burst limit
        send_pixels(16'h0000, 6'd1);
        send_window(9'd240, 9'd0, 9'd10, 9'd10);     // left column off screen
        send_window(9'd0, 9'd320, 9'd10, 9'd10);     // top row off screen
        send_window(9'd5, 9'd5, 9'd0, 9'd10);        // zero width
        send_window(9'd5, 9'd5, 9'd10, 9'd0);        // zero height
        send_window(9'd511, 9'd511, 9'd511, 9'd511);
        send_pixels(16'hA55A, 6'd32);                // budget survived the rejects
        send_window(9'd230, 9'd310, 9'd511, 9'd511); // clipped to 10 x 10
        repeat (4) send_pixels(16'h5AA5, 6'd63);     // 32, 32, 32, then 4
        send_pixels(16'h0F0F, 6'd10);                // window exhausted
        send_rotate(2'd1);
        send_window(9'd319, 9'd0, 9'd1, 9'd1);       // only valid in landscape
        send_rotate(2'd2);                           // ends the open write
        send_pixels(16'hF00F, 6'd8);
        send_rotate(2'd3);
        send_window(9'd0, 9'd239, 9'd511, 9'd1);     // full landscape row
        send_rotate(2'd0);

        // Random part: mostly window-then-pixels sequences, some noise.
        sent       = 0;
        next_pause = 60;
        while (sent < ITEM_GOAL) begin
            calm = (sent >= 120 && sent < 180);
            if (sent >= next_pause) begin
                drain_stream();
                next_pause += 150;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_rotate(2'($urandom));
                    sent++;
                end
                x = 9'($urandom_range(0, book.scr_w - 1));
                y = 9'($urandom_range(0, book.scr_h - 1));
                if ($urandom_range(0, 3) == 0) begin
                    w = 9'($urandom_range(1, 511));
                    h = 9'($urandom_range(1, 511));
                end else begin
                    w = 9'($urandom_range(1, 12));
                    h = 9'($urandom_range(1, 12));
                end
                send_window(x, y, w, h);
                sent++;
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_pixels(16'($urandom), 6'($urandom_range(0, 63)));
                    end else begin
                        send_pixels(16'($urandom), 6'($urandom_range(1, 32)));
                    end
                    sent++;
                end
            end else if (pick < 70) begin
                send_window(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
                sent++;
            end else if (pick < 80) begin
                send_rotate(2'($urandom));
                sent++;
            end else if (pick < 92) begin
                send_pixels(16'($urandom), 6'($urandom_range(0, 63)));
                sent++;
            end else begin
                send_none();
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (book.due_bytes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (book.failures == 0 && book.due_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
